// ----- hw/rtl/odometry_move_to_servo_pulse_unit_macros.svh -----
// Assertion macros for the odometry move to servo pulse unit.
// Define NO_ASSERTIONS to compile the assertions out; expects clk and rst in scope.
`ifndef ODOMETRY_MOVE_TO_SERVO_PULSE_UNIT_MACROS_SVH
`define ODOMETRY_MOVE_TO_SERVO_PULSE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property outside reset.
`define OMSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define OMSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OMSP_ASSERT(label, prop, msg)
`define OMSP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- hw/rtl/omsp_pkg.sv -----
// Shared types and constants for the odometry move to servo pulse unit.
// No dependencies.
package omsp_pkg;

  // Request codes carried in req_type; code three acts as stop.
  localparam logic [1:0] REQ_STOP    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_ROTATE  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_FWD_TRIM  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_BWD_TRIM  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_FWD_TRIM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_BWD_TRIM = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_MIRROR    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_MIRROR   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_REST_POWER_OFF = 3'd6;

  // Field widths.
  localparam int unsigned TRIM_W  = 10;
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned CALC_W  = 13;

  // Wheel speeds in percent; the fixed rudder of one half is folded in.
  localparam logic signed [SPEED_W-1:0] SPEED_ADV_FAST = 7'sd30;
  localparam logic signed [SPEED_W-1:0] SPEED_ADV_SLOW = 7'sd15;
  localparam logic signed [SPEED_W-1:0] SPEED_ROTATE   = 7'sd10;
  localparam logic signed [SPEED_W-1:0] SPEED_ZERO     = 7'sd0;

  // Neutral pulse; the mirror around 3000 is 1500 minus the speed term.
  localparam logic signed [CALC_W-1:0] NEUTRAL_PULSE = 13'sd1500;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_ROTATE  = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [TRIM_W-1:0] fwd_trim;
    logic signed [TRIM_W-1:0] bwd_trim;
    logic                     mirror;
    logic                     rest_off;
  } wheel_cfg_t;

endpackage

// ----- hw/rtl/omsp_wheel.sv -----
// Speed to servo pulse mapping for one wheel: scale, mirror, trim, power off.
// Depends on omsp_pkg.
module omsp_wheel import omsp_pkg::*; (
  input  logic signed [SPEED_W-1:0] speed,
  input  wheel_cfg_t                cfg,
  output logic [PULSE_W-1:0]        pulse,
  output logic                      off
);

  logic signed [CALC_W-1:0] speed_ext;
  logic signed [CALC_W-1:0] speed_x5;
  logic signed [CALC_W-1:0] base;
  logic signed [CALC_W-1:0] trimmed;

  always_comb begin
    speed_ext = {{(CALC_W-SPEED_W){speed[SPEED_W-1]}}, speed};
    speed_x5  = (speed_ext <<< 2) + speed_ext;
    base      = cfg.mirror ? (NEUTRAL_PULSE - speed_x5) : (NEUTRAL_PULSE + speed_x5);
    priority if (base > NEUTRAL_PULSE) begin
      trimmed = base + {{(CALC_W-TRIM_W){cfg.fwd_trim[TRIM_W-1]}}, cfg.fwd_trim};
    end else if (base < NEUTRAL_PULSE) begin
      trimmed = base + {{(CALC_W-TRIM_W){cfg.bwd_trim[TRIM_W-1]}}, cfg.bwd_trim};
    end else begin
      trimmed = base;
    end
    if (cfg.rest_off && speed == SPEED_ZERO) begin
      pulse = '0;
      off   = 1'b1;
    end else begin
      pulse = trimmed[PULSE_W-1:0];
      off   = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/odometry_move_to_servo_pulse_unit.sv -----
// Top level of the odometry move to servo pulse unit: move tracking and output stage.
// Depends on omsp_pkg, omsp_wheel and odometry_move_to_servo_pulse_unit_macros.svh.
//
// Usage
//   Input channel (in_valid/in_ready): one beat per odometry tick carries a
//   request (stop, advance, rotate), a signed amount and the mouse x and y.
//   Output channel (out_valid/out_ready): one beat per input beat with both
//   servo pulse widths, the power-off flags and busy_res.
//   Config port: cfg_we/cfg_index/cfg_data write the trims, mirrors and the
//   rest power-off flag; write only while the block is idle.
//   Timing: a beat passes the input register, then the result register,
//   with the move compare and pulse logic as a single combinational pass
//   between those two registers. Throughput: one beat per cycle while
//   out_ready stays high.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more beat, after which in_ready drops.
//   Reset (rst, synchronous): both stages empty, move state idle with zero
//   start and target, trims zero, left mirror on, right mirror off,
//   rest power off disabled.
`include "odometry_move_to_servo_pulse_unit_macros.svh"
module odometry_move_to_servo_pulse_unit import omsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              req_type,
  input  logic signed [15:0]      amount,
  input  logic signed [15:0]      pos_x,
  input  logic signed [15:0]      pos_y,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PULSE_W-1:0]      left_pulse,
  output logic [PULSE_W-1:0]      right_pulse,
  output logic                    left_off,
  output logic                    right_off,
  output logic                    busy_res,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers.
  wheel_cfg_t left_cfg;
  wheel_cfg_t right_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cfg  <= '{fwd_trim: '0, bwd_trim: '0, mirror: 1'b1, rest_off: 1'b0};
      right_cfg <= '{fwd_trim: '0, bwd_trim: '0, mirror: 1'b0, rest_off: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_FWD_TRIM:  left_cfg.fwd_trim  <= cfg_data[TRIM_W-1:0];
        CFG_LEFT_BWD_TRIM:  left_cfg.bwd_trim  <= cfg_data[TRIM_W-1:0];
        CFG_RIGHT_FWD_TRIM: right_cfg.fwd_trim <= cfg_data[TRIM_W-1:0];
        CFG_RIGHT_BWD_TRIM: right_cfg.bwd_trim <= cfg_data[TRIM_W-1:0];
        CFG_LEFT_MIRROR:    left_cfg.mirror    <= cfg_data[0];
        CFG_RIGHT_MIRROR:   right_cfg.mirror   <= cfg_data[0];
        CFG_REST_POWER_OFF: begin
          // one flag shared by both wheels
          left_cfg.rest_off  <= cfg_data[0];
          right_cfg.rest_off <= cfg_data[0];
        end
        default: ;
      endcase
    end
  end

  // Input register.
  logic               in_full;
  logic [1:0]         req_q;
  logic signed [15:0] amount_q;
  logic signed [15:0] pos_x_q;
  logic signed [15:0] pos_y_q;
  logic               fire;

  // Advance the input register into the result register when the result is
  // empty or being taken this cycle.
  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q    <= req_type;
      amount_q <= amount;
      pos_x_q  <= pos_x;
      pos_y_q  <= pos_y;
    end
  end

  // Move state.
  mode_t              mode;
  logic signed [15:0] start_pos;
  logic [16:0]        target_mag;
  logic               backward;

  logic               is_adv;
  logic               is_rot;
  mode_t              req_mode;
  logic               fresh;
  logic signed [15:0] pos_sel;
  logic signed [15:0] start_next;
  logic [16:0]        target_next;
  logic               backward_next;
  logic signed [16:0] travel;
  logic [15:0]        travel_abs;
  logic [19:0]        dist_x5;
  logic [19:0]        target_x3;
  logic signed [17:0] remain;
  logic [23:0]        dist_x90;
  logic [23:0]        target_x21;
  logic signed [SPEED_W-1:0] speed_l;
  logic signed [SPEED_W-1:0] speed_r;
  logic               busy_next;

  always_comb begin
    is_adv   = (req_q == REQ_ADVANCE);
    is_rot   = (req_q == REQ_ROTATE);
    req_mode = is_adv ? MODE_ADVANCE : MODE_ROTATE;
    fresh    = (mode != req_mode);
    pos_sel  = is_adv ? pos_y_q : pos_x_q;

    // Latch a new move when the request type differs from the running one.
    if (fresh) begin
      start_next    = pos_sel;
      backward_next = amount_q[15];
      target_next   = amount_q[15] ? (17'd0 - {amount_q[15], amount_q})
                                   : {1'b0, amount_q};
    end else begin
      start_next    = start_pos;
      backward_next = backward;
      target_next   = target_mag;
    end

    travel     = {pos_sel[15], pos_sel} - {start_next[15], start_next};
    travel_abs = travel[16] ? 16'(17'd0 - travel) : travel[15:0];

    // Exact forms of 0.6*D and degrees*21/90.
    dist_x5    = ({4'd0, travel_abs} << 2) + {4'd0, travel_abs};
    target_x3  = ({3'd0, target_next} << 1) + {3'd0, target_next};
    remain     = $signed({1'b0, target_next}) - $signed({2'b00, travel_abs});
    dist_x90   = ({8'd0, travel_abs} * 24'd90);
    target_x21 = ({7'd0, target_next} * 24'd21);

    speed_l   = SPEED_ZERO;
    speed_r   = SPEED_ZERO;
    busy_next = 1'b0;
    priority if (is_adv) begin
      priority if (dist_x5 < target_x3 && remain > 18'sd3 && !backward_next) begin
        speed_l   = SPEED_ADV_FAST;
        speed_r   = SPEED_ADV_FAST;
        busy_next = 1'b1;
      end else if ({1'b0, travel_abs} < target_next) begin
        speed_l   = backward_next ? -SPEED_ADV_SLOW : SPEED_ADV_SLOW;
        speed_r   = speed_l;
        busy_next = 1'b1;
      end
    end else if (is_rot) begin
      if (dist_x90 < target_x21) begin
        speed_l   = backward_next ? -SPEED_ROTATE : SPEED_ROTATE;
        speed_r   = -speed_l;
        busy_next = 1'b1;
      end
    end
  end

  // Update the move state as the beat leaves the input register; a stop
  // leaves it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      start_pos  <= '0;
      target_mag <= '0;
      backward   <= 1'b0;
    end else if (fire && (is_adv || is_rot)) begin
      mode       <= busy_next ? req_mode : MODE_IDLE;
      start_pos  <= start_next;
      target_mag <= target_next;
      backward   <= backward_next;
    end
  end

  // Pulse mapping.
  logic [PULSE_W-1:0] left_pulse_next;
  logic [PULSE_W-1:0] right_pulse_next;
  logic               left_off_next;
  logic               right_off_next;

  omsp_wheel u_left (
    .speed (speed_l),
    .cfg   (left_cfg),
    .pulse (left_pulse_next),
    .off   (left_off_next)
  );

  omsp_wheel u_right (
    .speed (speed_r),
    .cfg   (right_cfg),
    .pulse (right_pulse_next),
    .off   (right_off_next)
  );

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      left_pulse  <= left_pulse_next;
      right_pulse <= right_pulse_next;
      left_off    <= left_off_next;
      right_off   <= right_off_next;
      busy_res    <= busy_next;
    end
  end

  // Assertions.
  `OMSP_ASSERT_ALWAYS(a_reset_empties, $past(rst) |-> !out_valid && !in_full, "stage full after reset")
  `OMSP_ASSERT(a_busy_powered, out_valid && busy_res |-> !left_off && !right_off, "wheel off during move")
  `OMSP_ASSERT(a_stop_not_busy, fire && !is_adv && !is_rot |=> !busy_res, "stop beat reported busy")
  `OMSP_ASSERT(a_done_idle, fire && !busy_next |=> mode == MODE_IDLE || $past(!is_adv && !is_rot), "finished move not idle")

endmodule
